// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro wraps one clocked concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Delayed implication from the antecedent to the consequent.
`define ASSERT_AFTER2(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("assertion failed: two-cycle implication");

`endif

// ===== rtl/core/dslsd_pkg.sv =====
// Package for the duty slew limiter and stall detector.
// Holds the item codes, register indexes and shared structure types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dslsd_pkg;

  localparam logic [2:0] KIND_DRIVE   = 3'd0;
  localparam logic [2:0] KIND_STOP    = 3'd1;
  localparam logic [2:0] KIND_CHECK   = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;

  localparam logic [2:0] REG_SLEW_STEP         = 3'd0;
  localparam logic [2:0] REG_DUTY_LIMIT        = 3'd1;
  localparam logic [2:0] REG_STALL_DUTY_LEVEL  = 3'd2;
  localparam logic [2:0] REG_STALL_SPEED_LEVEL = 3'd3;
  localparam logic [2:0] REG_STALL_TIMEOUT     = 3'd4;

  localparam logic [15:0]        RST_SLEW_STEP         = 16'd5;
  localparam logic [14:0]        RST_DUTY_LIMIT        = 15'd100;
  localparam logic [14:0]        RST_STALL_DUTY_LEVEL  = 15'd60;
  localparam logic signed [15:0] RST_STALL_SPEED_LEVEL = 16'sd50;
  localparam logic [31:0]        RST_STALL_TIMEOUT     = 32'd1000;

  typedef struct packed {
    logic [15:0]        slew_step;
    logic [14:0]        duty_limit;
    logic [14:0]        stall_duty_level;
    logic signed [15:0] stall_speed_level;
    logic [31:0]        stall_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] duty_request;
    logic signed [15:0] encoder_speed;
    logic [31:0]        time_now;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] duty_applied;
    logic               stall_confirmed;
    logic               stall_pending;
  } result_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/dslsd_if.sv =====
// Channel interfaces of the duty slew limiter: command, result and register write.
// Each carries valid, ready and its payload; uses no package.
`timescale 1ns / 1ps
`default_nettype none

interface dslsd_cmd_if ();
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [15:0] duty_request;
  logic signed [15:0] encoder_speed;
  logic [31:0]        time_now;

  modport source (output valid, kind, duty_request, encoder_speed, time_now, input ready);
  modport sink (input valid, kind, duty_request, encoder_speed, time_now, output ready);
endinterface

interface dslsd_res_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] duty_applied;
  logic               stall_confirmed;
  logic               stall_pending;

  modport source (output valid, duty_applied, stall_confirmed, stall_pending, input ready);
  modport sink (input valid, duty_applied, stall_confirmed, stall_pending, output ready);
endinterface

interface dslsd_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dslsd_cfg_regs.sv =====
// Configuration register file of the duty slew limiter.
// Depends on dslsd_pkg and the register write interface.
`timescale 1ns / 1ps
`default_nettype none

module dslsd_cfg_regs import dslsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dslsd_cfg_if.sink   cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slew_step         <= RST_SLEW_STEP;
      regs.duty_limit        <= RST_DUTY_LIMIT;
      regs.stall_duty_level  <= RST_STALL_DUTY_LEVEL;
      regs.stall_speed_level <= RST_STALL_SPEED_LEVEL;
      regs.stall_timeout     <= RST_STALL_TIMEOUT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SLEW_STEP:         regs.slew_step         <= cfg.data[15:0];
        REG_DUTY_LIMIT:        regs.duty_limit        <= cfg.data[14:0];
        REG_STALL_DUTY_LEVEL:  regs.stall_duty_level  <= cfg.data[14:0];
        REG_STALL_SPEED_LEVEL: regs.stall_speed_level <= $signed(cfg.data[15:0]);
        REG_STALL_TIMEOUT:     regs.stall_timeout     <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dslsd_in_reg.sv =====
// Input register of the duty slew limiter: captures one command per cycle
// while free or advancing. Depends on dslsd_pkg and the command interface.
`timescale 1ns / 1ps
`default_nettype none

module dslsd_in_reg import dslsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dslsd_cmd_if.sink  cmd,
  input  logic       advance,
  output stage_t     stage
);

  logic take;

  assign cmd.ready = !stage.valid || advance;
  assign take      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (take) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage.cmd.kind          <= cmd.kind;
      stage.cmd.duty_request  <= cmd.duty_request;
      stage.cmd.encoder_speed <= cmd.encoder_speed;
      stage.cmd.time_now      <= cmd.time_now;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dslsd_exec.sv =====
// Execute stage: slew limit, clamp and stall timing, with the state and result registers.
// Depends on dslsd_pkg and the result interface.
`timescale 1ns / 1ps
`default_nettype none

module dslsd_exec import dslsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        regs,
  input  stage_t      stage,
  output logic        advance,
  dslsd_res_if.source res
);

  logic signed [15:0] last_duty;
  logic signed [15:0] last_duty_next;
  logic               stall_timing;
  logic               stall_timing_next;
  logic [31:0]        stall_onset;
  logic [31:0]        stall_onset_next;
  logic               confirmed;
  logic               res_valid;
  result_t            result;

  logic signed [17:0] req_w;
  logic signed [17:0] last_w;
  logic signed [17:0] step_w;
  logic signed [17:0] lim_w;
  logic signed [17:0] delta;
  logic signed [17:0] slewed;
  logic signed [17:0] clamped;
  logic [16:0]        mag;
  logic               cond;
  logic [31:0]        onset_used;
  logic [31:0]        elapsed;

  assign advance = stage.valid && (!res_valid || res.ready);

  always_comb begin
    req_w  = 18'(stage.cmd.duty_request);
    last_w = 18'(last_duty);
    step_w = $signed({2'b00, regs.slew_step});
    lim_w  = $signed({3'b000, regs.duty_limit});
    delta  = req_w - last_w;
    if (delta > step_w) begin
      slewed = last_w + step_w;
    end else if (delta < -step_w) begin
      slewed = last_w - step_w;
    end else begin
      slewed = req_w;
    end
    if (slewed > lim_w) begin
      clamped = lim_w;
    end else if (slewed < -lim_w) begin
      clamped = -lim_w;
    end else begin
      clamped = slewed;
    end

    mag        = last_duty[15] ? 17'(-17'(last_duty)) : 17'(last_duty);
    cond       = (mag >= {2'b00, regs.stall_duty_level}) &&
                 (stage.cmd.encoder_speed <= regs.stall_speed_level);
    onset_used = stall_timing ? stall_onset : stage.cmd.time_now;
    elapsed    = stage.cmd.time_now - onset_used;
  end

  always_comb begin
    last_duty_next    = last_duty;
    stall_timing_next = stall_timing;
    stall_onset_next  = stall_onset;
    confirmed         = 1'b0;
    unique case (stage.cmd.kind)
      KIND_DRIVE: begin
        last_duty_next = clamped[15:0];
      end
      KIND_STOP: begin
        last_duty_next = '0;
      end
      KIND_CHECK: begin
        if (cond) begin
          stall_timing_next = 1'b1;
          stall_onset_next  = onset_used;
          confirmed         = (elapsed >= regs.stall_timeout);
        end else begin
          stall_timing_next = 1'b0;
        end
      end
      KIND_CLEAR: begin
        stall_timing_next = 1'b0;
        stall_onset_next  = '0;
      end
      KIND_RESTART: begin
        last_duty_next    = '0;
        stall_timing_next = 1'b0;
        stall_onset_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_duty    <= '0;
      stall_timing <= 1'b0;
      stall_onset  <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (advance) begin
        last_duty    <= last_duty_next;
        stall_timing <= stall_timing_next;
        stall_onset  <= stall_onset_next;
        res_valid    <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.duty_applied    <= last_duty_next;
      result.stall_confirmed <= confirmed;
      result.stall_pending   <= stall_timing_next;
    end
  end

  assign res.valid           = res_valid;
  assign res.duty_applied    = result.duty_applied;
  assign res.stall_confirmed = result.stall_confirmed;
  assign res.stall_pending   = result.stall_pending;

endmodule

`default_nettype wire

// ===== rtl/core/duty_slew_limit_stall_detect.sv =====
// Top level of the motor duty conditioner with slew limit, clamp and stall timeout.
// Depends on dslsd_pkg, the channel interfaces and the dslsd submodules.
//
// The block accepts one command transaction in every cycle while results are
// taken, and returns exactly one result transaction for each, in order. A
// command is captured in the input register at its accepting edge and its
// result is loaded into the result register at the next edge when that
// register is free or being taken, and stays valid until it is taken. A
// result that is held back keeps the input register occupied, and the input
// stalls once both registers are full. The execute stage between them holds
// the duty and stall state, so consecutive commands see each other's effect
// with no gap. Register writes are always ready and apply to commands that
// reach the execute stage after the write.
`timescale 1ns / 1ps
`default_nettype none

module duty_slew_limit_stall_detect import dslsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dslsd_cmd_if.sink   cmd,
  dslsd_res_if.source result,
  dslsd_cfg_if.sink   cfg
);

  cfg_t   regs;
  stage_t stage;
  logic   advance;

  dslsd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dslsd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .stage   (stage)
  );

  dslsd_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .stage   (stage),
    .advance (advance),
    .res     (result)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dslsd_checker.sv =====
// Port-level checker for the duty slew limiter, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dslsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_duty,
  input logic        res_confirmed,
  input logic        res_pending
);

  logic [17:0] res_payload;

  assign res_payload = {res_duty, res_confirmed, res_pending};

  // A confirmed stall is only reported while the condition is being timed.
  `ASSERT_IMPLY(a_confirm_pending, clk, rst, res_valid && res_confirmed, res_pending)

  // Every accepted command is followed later by a waiting result.
  `ASSERT_AFTER2(a_result_follows, clk, rst, cmd_valid && cmd_ready, res_valid)

  // A stalled result stays valid.
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res_payload))

endmodule

bind duty_slew_limit_stall_detect dslsd_checker u_dslsd_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_duty      (result.duty_applied),
  .res_confirmed (result.stall_confirmed),
  .res_pending   (result.stall_pending)
);

`default_nettype wire

// ===== dv/duty_slew_limit_stall_detect_tb.sv =====
// Testbench for the motor duty conditioner: slew limit, clamp and stall timeout.
// Predicts every result transaction in order and checks it field by field.
// Depends on dslsd_pkg, the channel interfaces and duty_slew_limit_stall_detect.
`timescale 1ns / 1ps

module duty_slew_limit_stall_detect_tb;
  import dslsd_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = KIND_RESTART + 3'd1;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [2:0] REG_UNMAPPED  = 3'd7;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 60;
  localparam int TAIL_CYCLES   = 8;
  localparam int BLOCK_ITEMS   = 110;

  typedef enum {STEP_CMD, STEP_REG, STEP_DRAIN, STEP_HOLD, STEP_MODE} step_kind_t;

  typedef struct {
    step_kind_t  what;
    cmd_t        cmd;
    logic [2:0]  reg_index;
    logic [31:0] reg_data;
    int          send_idle;
    int          recv_idle;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dslsd_cmd_if cmd_ch ();
  dslsd_res_if res_ch ();
  dslsd_cfg_if cfg_ch ();

  duty_slew_limit_stall_detect dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  step_t   cmd_plan[$];
  result_t duty_results_due[$];

  cfg_t               cfg_model = '{RST_SLEW_STEP, RST_DUTY_LIMIT, RST_STALL_DUTY_LEVEL,
                                    RST_STALL_SPEED_LEVEL, RST_STALL_TIMEOUT};
  logic signed [15:0] duty_state = '0;
  logic               timing_on  = 1'b0;
  logic [31:0]        onset_ms   = '0;

  bit cmd_took = 1'b0;
  bit cfg_took = 1'b0;
  bit cmd_busy = 1'b0;
  bit cfg_busy = 1'b0;
  int settle_left = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int mismatches = 0;
  int n_cmds = 0;
  int n_checks = 0;
  int n_confirms = 0;
  int n_writes = 0;

  logic [31:0] ms_clock = '0;
  int          plan_limit = RST_DUTY_LIMIT;
  int          plan_speed_level = RST_STALL_SPEED_LEVEL;

  initial begin
    cmd_ch.valid         = 1'b0;
    cmd_ch.kind          = KIND_DRIVE;
    cmd_ch.duty_request  = '0;
    cmd_ch.encoder_speed = '0;
    cmd_ch.time_now      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_SLEW_STEP;
    cfg_ch.data          = '0;
    res_ch.ready         = 1'b0;
  end

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic result_t condition_duty(cmd_t c);
    result_t     r;
    int          step;
    int          lim;
    int          want;
    int          delta;
    int          mag;
    logic [31:0] elapsed;
    step = int'(cfg_model.slew_step);
    lim  = int'(cfg_model.duty_limit);
    r.stall_confirmed = 1'b0;
    case (c.kind)
      KIND_DRIVE: begin
        want  = int'($signed(c.duty_request));
        delta = want - int'(duty_state);
        if (delta > step) want = int'(duty_state) + step;
        if (delta < -step) want = int'(duty_state) - step;
        if (want > lim) want = lim;
        if (want < -lim) want = -lim;
        duty_state = 16'(want);
      end
      KIND_STOP: duty_state = '0;
      KIND_CHECK: begin
        mag = int'(duty_state);
        if (mag < 0) mag = -mag;
        if (mag >= int'(cfg_model.stall_duty_level) &&
            int'($signed(c.encoder_speed)) <= int'($signed(cfg_model.stall_speed_level))) begin
          if (!timing_on) begin
            timing_on = 1'b1;
            onset_ms  = c.time_now;
          end
          elapsed = c.time_now - onset_ms;
          r.stall_confirmed = (elapsed >= cfg_model.stall_timeout);
        end else begin
          timing_on = 1'b0;
        end
      end
      KIND_CLEAR: begin
        timing_on = 1'b0;
        onset_ms  = '0;
      end
      KIND_RESTART: begin
        duty_state = '0;
        timing_on  = 1'b0;
        onset_ms   = '0;
      end
      default: ;
    endcase
    r.duty_applied  = duty_state;
    r.stall_pending = timing_on;
    return r;
  endfunction

  task automatic plan_cmd(logic [2:0] kind, logic [15:0] req, logic [15:0] speed,
                          logic [31:0] now);
    step_t s;
    s.what = STEP_CMD;
    s.cmd  = '{kind, req, speed, now};
    cmd_plan.push_back(s);
  endtask

  task automatic plan_drain();
    step_t s;
    s.what = STEP_DRAIN;
    cmd_plan.push_back(s);
  endtask

  task automatic plan_reg(logic [2:0] index, logic [31:0] data);
    step_t s;
    plan_drain();
    s.what      = STEP_REG;
    s.reg_index = index;
    s.reg_data  = data;
    cmd_plan.push_back(s);
  endtask

  task automatic plan_random_items(int count);
    cmd_t c;
    int   roll;
    int   value;
    for (int i = 0; i < count; i++) begin
      roll            = $urandom_range(99);
      c.kind          = 3'($urandom);
      c.duty_request  = 16'($urandom);
      c.encoder_speed = 16'($urandom);
      c.time_now      = $urandom;
      if (roll >= 8) begin
        ms_clock   = ms_clock + $urandom_range(9);
        c.time_now = ms_clock;
        if ($urandom_range(9) < 6) begin
          value = plan_limit - int'($urandom_range(30));
          if ($urandom_range(1) != 0) value = -value;
          c.duty_request = 16'(value);
        end
        if ($urandom_range(9) < 7) begin
          value = plan_speed_level - int'($urandom_range(300));
          if (value < -32768) value = -32768;
          c.encoder_speed = 16'(value);
        end
        if (roll < 48) c.kind = KIND_DRIVE;
        else if (roll < 85) c.kind = KIND_CHECK;
        else if (roll < 90) c.kind = KIND_STOP;
        else if (roll < 94) c.kind = KIND_CLEAR;
        else if (roll < 97) c.kind = KIND_RESTART;
        else c.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
      end
      plan_cmd(c.kind, c.duty_request, c.encoder_speed, c.time_now);
    end
  endtask

  // Command, register write and pacing driver.
  always @(negedge clk) begin
    step_t s;
    if (!rst) begin
      if (cmd_took) cmd_busy = 1'b0;
      if (cfg_took) cfg_busy = 1'b0;
      if (!cmd_busy && !cfg_busy) begin
        if (settle_left != 0) begin
          settle_left--;
        end else if (cmd_plan.size() != 0) begin
          s = cmd_plan[0];
          case (s.what)
            STEP_CMD: begin
              if ($urandom_range(99) >= send_idle_pct) begin
                void'(cmd_plan.pop_front());
                cmd_ch.kind          <= s.cmd.kind;
                cmd_ch.duty_request  <= s.cmd.duty_request;
                cmd_ch.encoder_speed <= s.cmd.encoder_speed;
                cmd_ch.time_now      <= s.cmd.time_now;
                cmd_busy = 1'b1;
              end
            end
            STEP_REG: begin
              void'(cmd_plan.pop_front());
              cfg_ch.index <= s.reg_index;
              cfg_ch.data  <= s.reg_data;
              cfg_busy = 1'b1;
            end
            STEP_DRAIN: begin
              if (duty_results_due.size() == 0) begin
                void'(cmd_plan.pop_front());
                settle_left = SETTLE_CYCLES;
              end
            end
            STEP_HOLD: begin
              void'(cmd_plan.pop_front());
              hold_seq <= hold_seq + 1;
            end
            STEP_MODE: begin
              void'(cmd_plan.pop_front());
              send_idle_pct = s.send_idle;
              recv_idle_pct <= s.recv_idle;
            end
          endcase
        end
      end
    end
    cmd_ch.valid <= cmd_busy;
    cfg_ch.valid <= cfg_busy;
  end

  // Result receiver with random stalls and the long hold-off.
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: applies register writes, predicts accepted commands, checks results.
  always @(posedge clk) begin
    result_t want;
    cmd_t    c;
    cmd_took = 1'b0;
    cfg_took = 1'b0;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SLEW_STEP:         cfg_model.slew_step         = cfg_ch.data[15:0];
          REG_DUTY_LIMIT:        cfg_model.duty_limit        = cfg_ch.data[14:0];
          REG_STALL_DUTY_LEVEL:  cfg_model.stall_duty_level  = cfg_ch.data[14:0];
          REG_STALL_SPEED_LEVEL: cfg_model.stall_speed_level = cfg_ch.data[15:0];
          REG_STALL_TIMEOUT:     cfg_model.stall_timeout     = cfg_ch.data;
          default: ;
        endcase
        cfg_took = 1'b1;
        n_writes++;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        c = '{cmd_ch.kind, cmd_ch.duty_request, cmd_ch.encoder_speed, cmd_ch.time_now};
        want = condition_duty(c);
        duty_results_due.push_back(want);
        cmd_took = 1'b1;
        n_cmds++;
        if (c.kind == KIND_CHECK) n_checks++;
        if (want.stall_confirmed) n_confirms++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (duty_results_due.size() == 0) begin
          $error("result transaction with no expectation waiting");
          mismatches++;
        end else begin
          want = duty_results_due.pop_front();
          if (res_ch.duty_applied !== want.duty_applied) begin
            $error("duty_applied: expected %0d, got %0d", want.duty_applied,
                   res_ch.duty_applied);
            mismatches++;
          end
          if (res_ch.stall_confirmed !== want.stall_confirmed) begin
            $error("stall_confirmed: expected %0b, got %0b", want.stall_confirmed,
                   res_ch.stall_confirmed);
            mismatches++;
          end
          if (res_ch.stall_pending !== want.stall_pending) begin
            $error("stall_pending: expected %0b, got %0b", want.stall_pending,
                   res_ch.stall_pending);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    step_t       s;
    logic [15:0] slew;
    logic [14:0] limit;
    logic [14:0] level;
    logic [15:0] speed_level;
    logic [31:0] timeout;
    int          send_pct[3];
    int          recv_pct[3];

    // Reset settings: small slew steps, then every other kind once.
    plan_cmd(KIND_DRIVE, 16'sh7FFF, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_DRIVE, 16'sh8000, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'sh8000, 32'hFFFF_FFFF);
    plan_cmd(KIND_SPARE_HI, 16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF);
    plan_cmd(KIND_STOP, 16'sh0000, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_RESTART, 16'sh0000, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_CLEAR, 16'sh0000, 16'sh0000, 32'h0000_0000);

    // Widest slew and clamp with a zero timeout: the onset check confirms at once.
    plan_reg(REG_SLEW_STEP, 32'hABCD_FFFF);
    plan_reg(REG_DUTY_LIMIT, 32'hFFFF_7FFF);
    plan_reg(REG_STALL_DUTY_LEVEL, 32'h0000_0000);
    plan_reg(REG_STALL_SPEED_LEVEL, 32'h0000_7FFF);
    plan_reg(REG_STALL_TIMEOUT, 32'h0000_0000);
    plan_cmd(KIND_DRIVE, 16'sh7FFF, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'sh7FFF, 32'h0000_0000);
    plan_cmd(KIND_DRIVE, 16'sh8000, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'sh0000, 32'h0000_007B);
    plan_cmd(KIND_SPARE_LO, 16'sh1234, 16'sh4321, 32'h5555_AAAA);

    // Timestamp wrap between onset and confirmation.
    plan_reg(REG_STALL_TIMEOUT, 32'd10);
    plan_reg(REG_STALL_SPEED_LEVEL, 32'hFFFF_8000);
    plan_reg(REG_STALL_DUTY_LEVEL, 32'h0000_7FFF);
    plan_cmd(KIND_CLEAR, 16'sh0000, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'sh8000, 32'hFFFF_FFF8);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'sh8000, 32'h0000_0003);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'sh8001, 32'h0000_0004);

    // Zero slew and clamp, longest timeout, and a write to an unmapped index.
    plan_reg(REG_DUTY_LIMIT, 32'h0000_0000);
    plan_reg(REG_SLEW_STEP, 32'h0000_0000);
    plan_reg(REG_STALL_TIMEOUT, 32'hFFFF_FFFF);
    plan_reg(REG_UNMAPPED, $urandom);
    plan_reg(REG_STALL_DUTY_LEVEL, 32'h0000_0000);
    plan_reg(REG_STALL_SPEED_LEVEL, 32'hFFFF_FFFF);
    plan_cmd(KIND_DRIVE, 16'sd1000, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_DRIVE, -16'sd5, 16'sh0000, 32'h0000_0000);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'shFFFF, 32'h0000_0000);
    plan_cmd(KIND_CHECK, 16'sh0000, 16'shFFFF, 32'hFFFF_FFFF);
    plan_cmd(KIND_RESTART, 16'sh0000, 16'sh0000, 32'h0000_0000);

    send_pct = '{12, 80, 0};
    recv_pct = '{80, 12, 0};
    for (int m = 0; m < 3; m++) begin
      plan_drain();
      s.what      = STEP_MODE;
      s.send_idle = send_pct[m];
      s.recv_idle = recv_pct[m];
      cmd_plan.push_back(s);
      for (int b = 0; b < 3; b++) begin
        if ($urandom_range(4) == 0) slew = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        else slew = 16'($urandom_range(3000, 1));
        if ($urandom_range(4) == 0) limit = ($urandom_range(1) != 0) ? 15'h7FFF : 15'h0000;
        else limit = 15'($urandom_range(32767, 50));
        level = ($urandom_range(5) == 0) ? 15'h7FFF : 15'($urandom_range(limit));
        speed_level = 16'($urandom);
        if ($urandom_range(4) == 0) timeout = ($urandom_range(1) != 0) ? '1 : '0;
        else timeout = $urandom_range(40);
        plan_reg(REG_SLEW_STEP, {16'($urandom), slew});
        plan_reg(REG_DUTY_LIMIT, {17'($urandom), limit});
        plan_reg(REG_STALL_DUTY_LEVEL, {17'($urandom), level});
        plan_reg(REG_STALL_SPEED_LEVEL, {16'($urandom), speed_level});
        plan_reg(REG_STALL_TIMEOUT, timeout);
        plan_limit       = int'(limit);
        plan_speed_level = int'($signed(speed_level));
        ms_clock = ($urandom_range(2) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
        plan_random_items(BLOCK_ITEMS / 2);
        if (b == 0) begin
          s.what = STEP_HOLD;
          cmd_plan.push_back(s);
        end
        if (b == 1) plan_drain();
        plan_random_items(BLOCK_ITEMS - BLOCK_ITEMS / 2);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_plan.size() != 0 || cmd_busy || cfg_busy) @(posedge clk);
    while (duty_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d command transactions and %0d register writes.", n_cmds,
             n_writes);
    $display("Stall checks: %0d, of which %0d confirmed a stall.", n_checks, n_confirms);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
